// ----- rtl/c_include_directive_scanner_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the include directive scanner
// Clocked on clk, disabled while arst_n is low; empty under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef C_INCLUDE_DIRECTIVE_SCANNER_ASSERT_SVH
`define C_INCLUDE_DIRECTIVE_SCANNER_ASSERT_SVH
`ifndef SYNTHESIS
`define CIDS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scanner assertion failed");
`define CIDS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scanner assertion failed");
`else
`define CIDS_ASSERT_IMP(lbl, ante, cons)
`define CIDS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/cids_pkg.sv -----
// ----------------------------------------------------------------------------
// cids_pkg
// Constants, command/status types and the keyword table of the scanner.
// ----------------------------------------------------------------------------
package cids_pkg;

	localparam int MAX_PATH_BYTES = 64;
	localparam int STORE_DEPTH    = 64;
	localparam int ADDR_W         = $clog2(STORE_DEPTH);
	localparam int CNT_W          = $clog2(MAX_PATH_BYTES + 1);
	localparam int KW_LEN         = 7;
	localparam int KW_W           = 3;

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_VT    = 8'd11;
	localparam logic [7:0] CH_FF    = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_DQ    = 8'h22;

	// Controller to datapath
	typedef struct packed {
		logic restart;     // back to line start: clear count, keyword, delimiter
		logic kw_first;    // first keyword letter matched
		logic kw_next;     // further keyword letter matched
		logic open;        // opening delimiter seen
		logic push;        // store one path word
		logic start_emit;  // closing delimiter seen, rewind read pointer
		logic issue;       // read one stored word toward the output
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_eol;
		logic is_blank;
		logic is_hash;
		logic is_lt;
		logic is_dq;
		logic is_close;
		logic is_kw0;
		logic kw_match;
		logic kw_last;
		logic count_full;
		logic issue_last;
		logic can_issue;
	} stat_t;

	function automatic logic [7:0] kw_char(input logic [KW_W-1:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = 8'h69; // i
			3'd1:    c = 8'h6E; // n
			3'd2:    c = 8'h63; // c
			3'd3:    c = 8'h6C; // l
			3'd4:    c = 8'h75; // u
			3'd5:    c = 8'h64; // d
			3'd6:    c = 8'h65; // e
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/cids_ctrl.sv -----
// ----------------------------------------------------------------------------
// cids_ctrl
// Line phase state machine; sequences path storage and emission.
// ----------------------------------------------------------------------------
`include "c_include_directive_scanner_assert.svh"

module cids_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  cids_pkg::stat_t stat,
	output cids_pkg::cmd_t  cmd
);

	typedef enum logic [7:0] {
		ST_LEAD_WS = 8'b0000_0001,
		ST_HASH_WS = 8'b0000_0010,
		ST_KEYWORD = 8'b0000_0100,
		ST_NEED_WS = 8'b0000_1000,
		ST_PATH_WS = 8'b0001_0000,
		ST_PATH    = 8'b0010_0000,
		ST_IGNORE  = 8'b0100_0000,
		ST_EMIT    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   acc;

	assign s_tready = (state_q != ST_EMIT);
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		if (state_q == ST_EMIT) begin
			if (stat.can_issue) begin
				cmd.issue = 1'b1;
				if (stat.issue_last) begin
					cmd.restart = 1'b1;
					state_d     = ST_IGNORE;
				end
			end
		end else if (acc) begin
			if (stat.is_eol) begin
				cmd.restart = 1'b1;
				state_d     = ST_LEAD_WS;
			end else begin
				case (state_q)
					ST_LEAD_WS: begin
						if (!stat.is_blank) begin
							state_d = stat.is_hash ? ST_HASH_WS : ST_IGNORE;
						end
					end
					ST_HASH_WS: begin
						if (!stat.is_blank) begin
							if (stat.is_kw0) begin
								cmd.kw_first = 1'b1;
								state_d      = ST_KEYWORD;
							end else begin
								state_d = ST_IGNORE;
							end
						end
					end
					ST_KEYWORD: begin
						if (stat.kw_match) begin
							cmd.kw_next = 1'b1;
							if (stat.kw_last) begin
								state_d = ST_NEED_WS;
							end
						end else begin
							state_d = ST_IGNORE;
						end
					end
					ST_NEED_WS: begin
						state_d = stat.is_blank ? ST_PATH_WS : ST_IGNORE;
					end
					ST_PATH_WS: begin
						if (!stat.is_blank) begin
							if (stat.is_lt || stat.is_dq) begin
								cmd.open = 1'b1;
								state_d  = ST_PATH;
							end else begin
								state_d = ST_IGNORE;
							end
						end
					end
					ST_PATH: begin
						if (stat.is_close) begin
							cmd.start_emit = 1'b1;
							state_d        = ST_EMIT;
						end else if (!stat.count_full) begin
							cmd.push = 1'b1;
						end else begin
							// overlong path: drop the line
							cmd.restart = 1'b1;
							state_d     = ST_IGNORE;
						end
					end
					ST_IGNORE: begin
						state_d = ST_IGNORE;
					end
					default: begin
						state_d = ST_IGNORE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LEAD_WS;
		end else begin
			state_q <= state_d;
		end
	end

	`CIDS_ASSERT_IMP(a_issue_no_accept, cmd.issue, !acc)
	`CIDS_ASSERT_IMP(a_push_in_path, cmd.push, acc && state_q == ST_PATH)
	`CIDS_ASSERT_NXT(a_last_leaves_emit, cmd.issue && stat.issue_last, state_q == ST_IGNORE)

endmodule

// ----- rtl/cids_dp.sv -----
// ----------------------------------------------------------------------------
// cids_dp
// Byte classifier, keyword pointer, path store, read stage and output register.
// ----------------------------------------------------------------------------
`include "c_include_directive_scanner_assert.svh"

module cids_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [7:0]                text_byte,
	input  cids_pkg::cmd_t            cmd,
	output cids_pkg::stat_t           stat,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                path_byte,
	output logic                      last_byte,
	output logic                      system_include,
	output logic                      empty_path,
	output logic [cids_pkg::CNT_W-1:0] path_length
);

	logic [7:0]                  store_mem [cids_pkg::STORE_DEPTH];
	logic [cids_pkg::CNT_W-1:0]  count_q;
	logic [cids_pkg::KW_W-1:0]   kw_pos_q;
	logic                        angle_q;
	logic [cids_pkg::ADDR_W-1:0] rd_k_q;

	// read stage
	logic                        vld_s1;
	logic [7:0]                  data_s1;
	logic                        last_s1;
	logic                        sys_s1;
	logic                        empty_s1;
	logic [cids_pkg::CNT_W-1:0]  len_s1;

	// output register
	logic                        m_vld_q;
	logic [7:0]                  m_data_q;
	logic                        m_last_q;
	logic                        m_sys_q;
	logic                        m_empty_q;
	logic [cids_pkg::CNT_W-1:0]  m_len_q;

	logic out_free, move, cnt_zero;

	assign out_free = !m_vld_q || m_tready;
	assign move     = vld_s1 && out_free;
	assign cnt_zero = (count_q == '0);

	always_comb begin
		stat.is_eol     = (text_byte == cids_pkg::CH_NL) || (text_byte == cids_pkg::CH_NUL);
		stat.is_blank   = (text_byte == cids_pkg::CH_SPACE) || (text_byte == cids_pkg::CH_TAB)
		               || (text_byte == cids_pkg::CH_VT) || (text_byte == cids_pkg::CH_FF)
		               || (text_byte == cids_pkg::CH_CR);
		stat.is_hash    = (text_byte == cids_pkg::CH_HASH);
		stat.is_lt      = (text_byte == cids_pkg::CH_LT);
		stat.is_dq      = (text_byte == cids_pkg::CH_DQ);
		stat.is_close   = (text_byte == (angle_q ? cids_pkg::CH_GT : cids_pkg::CH_DQ));
		stat.is_kw0     = (text_byte == cids_pkg::kw_char('0));
		stat.kw_match   = (kw_pos_q < cids_pkg::KW_W'(cids_pkg::KW_LEN))
		               && (text_byte == cids_pkg::kw_char(kw_pos_q));
		stat.kw_last    = (kw_pos_q == cids_pkg::KW_W'(cids_pkg::KW_LEN - 1));
		stat.count_full = (count_q >= cids_pkg::CNT_W'(cids_pkg::MAX_PATH_BYTES));
		stat.issue_last = cnt_zero
		               || (({1'b0, rd_k_q} + cids_pkg::CNT_W'(1)) == count_q);
		stat.can_issue  = !vld_s1 || out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			kw_pos_q <= '0;
			angle_q  <= 1'b0;
			rd_k_q   <= '0;
		end else begin
			if (cmd.restart) begin
				count_q  <= '0;
				kw_pos_q <= '0;
				angle_q  <= 1'b0;
			end else begin
				if (cmd.kw_first) begin
					kw_pos_q <= cids_pkg::KW_W'(1);
				end else if (cmd.kw_next) begin
					kw_pos_q <= kw_pos_q + cids_pkg::KW_W'(1);
				end
				if (cmd.open) begin
					angle_q <= stat.is_lt;
					count_q <= '0;
				end else if (cmd.push) begin
					count_q <= count_q + cids_pkg::CNT_W'(1);
				end
			end
			if (cmd.start_emit) begin
				rd_k_q <= '0;
			end else if (cmd.issue) begin
				rd_k_q <= rd_k_q + cids_pkg::ADDR_W'(1);
			end
		end
	end

	// path store: write on push, registered read on issue
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			store_mem[count_q[cids_pkg::ADDR_W-1:0]] <= text_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			data_s1  <= cnt_zero ? 8'd0 : store_mem[rd_k_q];
			last_s1  <= stat.issue_last;
			sys_s1   <= angle_q;
			empty_s1 <= cnt_zero;
			len_s1   <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			m_vld_q <= 1'b0;
		end else begin
			if (cmd.issue) begin
				vld_s1 <= 1'b1;
			end else if (move) begin
				vld_s1 <= 1'b0;
			end
			if (move) begin
				m_vld_q <= 1'b1;
			end else if (m_tready) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			m_data_q  <= data_s1;
			m_last_q  <= last_s1;
			m_sys_q   <= sys_s1;
			m_empty_q <= empty_s1;
			m_len_q   <= len_s1;
		end
	end

	assign m_tvalid       = m_vld_q;
	assign path_byte      = m_data_q;
	assign last_byte      = m_last_q;
	assign system_include = m_sys_q;
	assign empty_path     = m_empty_q;
	assign path_length    = m_len_q;

	`CIDS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= cids_pkg::CNT_W'(cids_pkg::MAX_PATH_BYTES))
	`CIDS_ASSERT_IMP(a_push_not_full, cmd.push, !stat.count_full)
	`CIDS_ASSERT_IMP(a_issue_has_room, cmd.issue, stat.can_issue)
	`CIDS_ASSERT_IMP(a_push_not_issue, cmd.push, !cmd.issue && !vld_s1 || !cmd.issue)

endmodule

// ----- rtl/c_include_directive_scanner.sv -----
// ----------------------------------------------------------------------------
// c_include_directive_scanner
// Scans source text for include directives and streams out the path words.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : one source word (text_byte) per handshake; newline or NUL ends a line.
//   m_* : one path word per handshake; tlast marks the final word of a path,
//         tuser flags system include and empty path, tdata also carries the
//         total path length on every word.
// Rate:
//   Text words are taken one per cycle while a line is scanned or stored.
//   The closing delimiter of a path stalls input while the store is read
//   out through one registered read port, one word a cycle while m_tready
//   lets the output drain; the first word passes the read stage and the
//   output register before it appears on m_*.
// Reset:
//   arst_n returns the scanner to line start with an empty store; no clearing
//   pass is run, so input is taken as soon as reset is released.
// Stall:
//   A read stage and an output register stand between the store and m_*;
//   when m_tready is low, readout pauses and the words wait, none lost.
// ----------------------------------------------------------------------------
module c_include_directive_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] path_byte, [14:8] path_length, [15] zero
	output logic        m_tlast,   // last_byte
	output logic [1:0]  m_tuser    // [0] system_include, [1] empty_path
);

	cids_pkg::cmd_t             cmd;
	cids_pkg::stat_t            stat;
	logic [7:0]                 path_byte;
	logic                       system_include;
	logic                       empty_path;
	logic [cids_pkg::CNT_W-1:0] path_length;

	// line phase controller: owns the input handshake
	cids_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: classify, store, read out, hold the output word
	cids_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.text_byte      (s_tdata),
		.cmd            (cmd),
		.stat           (stat),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.path_byte      (path_byte),
		.last_byte      (m_tlast),
		.system_include (system_include),
		.empty_path     (empty_path),
		.path_length    (path_length)
	);

	// pack the output word, pad to whole bytes
	assign m_tdata = {1'b0, path_length, path_byte};
	assign m_tuser = {empty_path, system_include};

endmodule
